>>> rtl/ssgt_pkg.sv
package ssgt_pkg;

  // Item kinds carried by each input beat
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_HEAD   = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_e;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W          = 3;
  localparam int unsigned CFG_DATA_W          = 32;
  localparam logic        REG_START_AT_LATEST = 1'b0;

  localparam int unsigned SEQ_W = 64;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        stream_id;
    logic [SEQ_W-1:0]  sequence_req;
  } in_beat_t;

  typedef struct packed {
    logic              deliver;
    logic              fetch;
    logic [SEQ_W-1:0]  fetch_start;
    logic [SEQ_W-1:0]  fetch_count;
  } out_beat_t;

  // One table word: stream known flag and last sequence
  typedef struct packed {
    logic              valid;
    logic [SEQ_W-1:0]  last;
  } entry_t;

  // Decision for one item: table update and result beat
  typedef struct packed {
    logic      wr_en;
    entry_t    wr_entry;
    out_beat_t res;
  } decision_t;

endpackage

>>> rtl/ssgt_cfg.sv
module ssgt_cfg
  import ssgt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  start_at_latest_o
);

  logic start_at_latest_q;
  logic reg_sel;

  // Word index of the access; only index zero exists
  assign reg_sel = (paddr[2] == REG_START_AT_LATEST);
  assign pready  = 1'b1;

  // Write the mode bit on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_at_latest_q <= 1'b1;
    end else if (psel && penable && pwrite && reg_sel) begin
      start_at_latest_q <= pwdata[0];
    end
  end

  // Read back the mode bit
  always_comb begin
    prdata = '0;
    if (reg_sel && (paddr[1:0] == 2'b00)) begin
      prdata[0] = start_at_latest_q;
    end
  end

  assign start_at_latest_o = start_at_latest_q;

endmodule

>>> rtl/ssgt_table.sv
module ssgt_table
  import ssgt_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_entry_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_entry_i,
  output logic          clearing_o
);

  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  entry_t        mem_q [DEPTH];
  entry_t        rd_q;
  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;

  // Sweep every entry to invalid after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == LastAddr) begin
        clearing_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // Write port: clearing pass has priority
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_q;
  assign clearing_o = clearing_q;

endmodule

>>> rtl/ssgt_decide.sv
module ssgt_decide
  import ssgt_pkg::*;
(
  input  in_beat_t  beat_i,
  input  logic      in_range_i,
  input  entry_t    entry_i,
  input  logic      start_at_latest_i,
  output decision_t dec_o
);

  logic             is_data;
  logic             is_head;
  logic             active;
  logic             init;
  logic             known;
  logic             deliver;
  logic             fetch;
  logic [SEQ_W-1:0] seq;
  logic [SEQ_W-1:0] last;
  logic [SEQ_W-1:0] last_p1;

  assign seq = beat_i.sequence_req;

  always_comb begin
    is_data = (beat_i.kind == KIND_DATA) || (beat_i.kind == KIND_DIRECT);
    is_head = (beat_i.kind == KIND_HEAD);
    active  = (is_data || is_head) && in_range_i;

    // Unknown stream in latest mode takes the item as its start point
    init = !entry_i.valid && start_at_latest_i;
    if (entry_i.valid) begin
      last = entry_i.last;
    end else if (init) begin
      last = is_data ? (seq - 1'b1) : seq;
    end else begin
      last = '1;
    end
    known   = entry_i.valid || init;
    last_p1 = last + 1'b1;

    // Gap check against the next expected sequence
    if (is_data) begin
      fetch = active && (!known || (seq > last_p1));
    end else begin
      fetch = active && (!known || (seq > last));
    end
    deliver = active && is_data && (seq == last_p1);

    dec_o.wr_en           = active && (init || deliver);
    dec_o.wr_entry.valid  = 1'b1;
    dec_o.wr_entry.last   = deliver ? seq : last;
    dec_o.res.deliver     = deliver;
    dec_o.res.fetch       = fetch;
    dec_o.res.fetch_start = fetch ? last_p1 : '0;
    dec_o.res.fetch_count = fetch ? (seq - last) : '0;
  end

endmodule

>>> rtl/stream_sequence_gap_tracker.sv
// In-order delivery tracker for up to STREAM_COUNT streams. One item is taken
// per clock while busy is low, and its result appears on res_o with
// res_strobe_o high for one cycle, once it has passed the stage-one and result registers; the
// receiver cannot stall, so every result must be captured when strobed. The
// rate is set by the single read-modify-write of the per-stream table: the
// table is read on acceptance, the decision is made and written back in the
// next cycle, and an item that follows on the same stream gets the freshly
// written entry forwarded. After reset a clearing pass marks every stream
// unknown, one entry per cycle; busy stays high for the whole pass and
// configuration writes are accepted meanwhile.
module stream_sequence_gap_tracker
  import ssgt_pkg::*;
#(
  parameter int unsigned STREAM_COUNT = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  in_beat_t              in_i,
  output logic                  res_strobe_o,
  output out_beat_t             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;

  logic          start_at_latest;
  logic          clearing;
  logic          accept;
  logic          in_range;
  logic [AW-1:0] in_addr;
  entry_t        rd_entry;
  entry_t        cur_entry;
  decision_t     dec;
  logic          wr_en;

  // Stage one: item whose table word is arriving
  logic          s1_vld_q;
  in_beat_t      s1_beat_q;
  logic          s1_in_range_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_fwd_q;
  entry_t        s1_fwd_entry_q;

  out_beat_t     res_q;
  logic          res_strobe_q;

  assign busy     = clearing;
  assign accept   = start && !busy;
  assign in_range = (32'(in_i.stream_id) < STREAM_COUNT);
  assign in_addr  = AW'(32'(in_i.stream_id));

  ssgt_cfg u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start_at_latest_o (start_at_latest)
  );

  ssgt_table #(
    .DEPTH (STREAM_COUNT),
    .AW    (AW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (in_addr),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (s1_addr_q),
    .wr_entry_i (dec.wr_entry),
    .clearing_o (clearing)
  );

  // Pick the forwarded word when the previous beat wrote the same entry
  assign cur_entry = s1_fwd_q ? s1_fwd_entry_q : rd_entry;

  ssgt_decide u_decide (
    .beat_i            (s1_beat_q),
    .in_range_i        (s1_in_range_q),
    .entry_i           (cur_entry),
    .start_at_latest_i (start_at_latest),
    .dec_o             (dec)
  );

  assign wr_en = s1_vld_q && dec.wr_en;

  // Advance the stage-one valid flag and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      s1_vld_q     <= accept;
      res_strobe_q <= s1_vld_q;
    end
  end

  // Capture the accepted beat and any forwarded entry
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_beat_q      <= in_i;
      s1_in_range_q  <= in_range;
      s1_addr_q      <= in_addr;
      s1_fwd_q       <= wr_en && (s1_addr_q == in_addr);
      s1_fwd_entry_q <= dec.wr_entry;
    end else begin
      s1_fwd_q       <= 1'b0;
    end
  end

  // Hold the result beat for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      res_q <= dec.res;
    end
  end

  assign res_o        = res_q;
  assign res_strobe_o = res_strobe_q;

  // Every accepted item yields exactly one strobed result
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 res_strobe_o)
    else $error("accepted item produced no result");

  // No item is in flight while the table is being cleared
  a_idle_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s1_vld_q && !wr_en)
    else $error("table access during clearing pass");

  // Forwarding only serves a beat that is in stage one
  a_fwd_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_vld_q)
    else $error("forward flag without a beat in stage one");

  // A result without fetch carries zero range fields
  a_no_fetch_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.fetch) |-> (res_o.fetch_start == '0) && (res_o.fetch_count == '0))
    else $error("fetch range set without fetch");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import ssgt_pkg::*;

  localparam int unsigned STREAMS     = 256;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam logic [CFG_ADDR_W-1:0] START_MODE_ADDR = CFG_ADDR_W'(4 * REG_START_AT_LATEST);
  localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  in_beat_t              in_i;
  logic                  res_strobe_o;
  out_beat_t             res_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Tracker state mirrored by the testbench
  bit                    latest_mode;
  bit                    seq_known [STREAMS];
  logic [SEQ_W-1:0]      seq_last  [STREAMS];

  out_beat_t             expected_decisions[$];
  int unsigned           idle_pct;
  int unsigned           mismatch_count;
  int unsigned           cycle_count;
  int unsigned           tracked_items;
  int unsigned           ignored_items;
  int unsigned           deliveries_seen;
  int unsigned           fetches_seen;

  stream_sequence_gap_tracker #(
    .STREAM_COUNT(STREAMS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_decisions.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Decide delivery and fetch for one item, and advance the stream table
  function automatic out_beat_t decide_delivery(in_beat_t beat);
    out_beat_t        res;
    logic [SEQ_W-1:0] last;
    bit               known;
    bit               is_data;
    bit               is_head;
    res     = '0;
    is_data = (beat.kind == KIND_DATA) || (beat.kind == KIND_DIRECT);
    is_head = (beat.kind == KIND_HEAD);
    if (!(is_data || is_head) || beat.stream_id >= STREAMS) return res;
    known = seq_known[beat.stream_id];
    last  = SEQ_MAX;
    if (known) begin
      last = seq_last[beat.stream_id];
    end else if (latest_mode) begin
      // first item of a stream is taken as the starting point
      last = is_data ? beat.sequence_req - 64'd1 : beat.sequence_req;
      seq_known[beat.stream_id] = 1'b1;
      seq_last[beat.stream_id]  = last;
      known = 1'b1;
    end
    if (is_data) res.fetch = !known || (beat.sequence_req > last + 64'd1);
    else res.fetch = !known || (beat.sequence_req > last);
    if (res.fetch) begin
      res.fetch_start = last + 64'd1;
      res.fetch_count = beat.sequence_req - last;
    end
    if (is_data && beat.sequence_req == last + 64'd1) begin
      res.deliver = 1'b1;
      seq_known[beat.stream_id] = 1'b1;
      seq_last[beat.stream_id]  = beat.sequence_req;
    end
    return res;
  endfunction

  function automatic void report_field(string name, logic [SEQ_W-1:0] exp_v,
                                       logic [SEQ_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    out_beat_t exp_res;
    if (rst_ni && res_strobe_o) begin
      if (expected_decisions.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        mismatch_count++;
      end else begin
        exp_res = expected_decisions.pop_front();
        report_field("deliver", SEQ_W'(exp_res.deliver), SEQ_W'(res_o.deliver));
        report_field("fetch", SEQ_W'(exp_res.fetch), SEQ_W'(res_o.fetch));
        report_field("fetch_start", exp_res.fetch_start, res_o.fetch_start);
        report_field("fetch_count", exp_res.fetch_count, res_o.fetch_count);
        if (res_o.deliver === 1'b1) deliveries_seen++;
        if (res_o.fetch === 1'b1) fetches_seen++;
      end
    end
  end

  // Present one beat, hold it until accepted, then idle at random
  task automatic send_item(kind_e kind, logic [7:0] sid, logic [SEQ_W-1:0] seq);
    in_beat_t beat;
    beat.kind         = kind;
    beat.stream_id    = sid;
    beat.sequence_req = seq;
    @(negedge clk_i);
    start <= 1'b1;
    in_i  <= beat;
    do @(posedge clk_i); while (busy);
    expected_decisions.push_back(decide_delivery(beat));
    if (kind == KIND_OTHER) ignored_items++;
    else tracked_items++;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Drop start and hold until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_access(bit wr, logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= START_MODE_ADDR;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr) latest_mode = wdata[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the start mode, then read it back
  task automatic set_start_mode(logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] rdata;
    cfg_access(1'b1, value, rdata);
    cfg_access(1'b0, '0, rdata);
    if (rdata !== CFG_DATA_W'(value[0])) begin
      $display("%0t: start mode readback expected %h actual %h", $time,
               CFG_DATA_W'(value[0]), rdata);
      mismatch_count++;
    end
  endtask

  task automatic test_reset_value();
    logic [CFG_DATA_W-1:0] rdata;
    cfg_access(1'b0, '0, rdata);
    if (rdata !== CFG_DATA_W'(1)) begin
      $display("%0t: start mode after reset expected %h actual %h", $time,
               CFG_DATA_W'(1), rdata);
      mismatch_count++;
    end
  endtask

  task automatic test_start_at_latest();
    idle_pct = 0;
    // in order, gap, stale and resumed data on one stream
    send_item(KIND_DATA,   8'd10, 64'd100);
    send_item(KIND_DIRECT, 8'd10, 64'd101);
    send_item(KIND_DATA,   8'd10, 64'd105);
    send_item(KIND_DATA,   8'd10, 64'd101);
    send_item(KIND_DIRECT, 8'd10, 64'd102);
    // head announcements: first seen, ahead, behind
    send_item(KIND_HEAD,   8'd11, 64'd50);
    send_item(KIND_HEAD,   8'd11, 64'd55);
    send_item(KIND_HEAD,   8'd11, 64'd40);
    send_item(KIND_OTHER,  8'd12, SEQ_MAX);
    // wrap of the next expected sequence
    send_item(KIND_DATA,   8'd255, SEQ_MAX);
    send_item(KIND_DATA,   8'd255, 64'd0);
    send_item(KIND_DATA,   8'd0, 64'd0);
    send_item(KIND_HEAD,   8'd0, SEQ_MAX);
    drain_results();
  endtask

  task automatic test_start_at_earliest();
    set_start_mode(32'd0);
    idle_pct = 0;
    send_item(KIND_DATA,   8'd20, 64'd0);
    send_item(KIND_DATA,   8'd21, 64'd7);
    send_item(KIND_DIRECT, 8'd21, SEQ_MAX);
    send_item(KIND_HEAD,   8'd22, 64'd3);
    send_item(KIND_HEAD,   8'd22, SEQ_MAX);
    send_item(KIND_OTHER,  8'd255, 64'd0);
    send_item(KIND_DATA,   8'd20, 64'd1);
    drain_results();
    set_start_mode(32'hFFFF_FFFF);
  endtask

  // Mostly in-order streams with random content, plus gaps, stale and noise
  task automatic send_random_item();
    logic [7:0]       sid;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] seq;
    kind_e            kind;
    int unsigned      pick;
    sid  = ($urandom_range(99) < 70) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    kind = $urandom_range(1) ? KIND_DATA : KIND_DIRECT;
    if (seq_known[sid]) base = seq_last[sid];
    else if (latest_mode) base = {$urandom, $urandom};
    else base = SEQ_MAX;
    pick = $urandom_range(99);
    if (pick < 45) begin
      seq = base + 64'd1;
    end else if (pick < 60) begin
      seq = base + 64'($urandom_range(20, 2));
    end else if (pick < 70) begin
      seq = base - 64'($urandom_range(5));
    end else if (pick < 82) begin
      kind = KIND_HEAD;
      seq  = base + 64'($urandom_range(10));
    end else if (pick < 90) begin
      kind = $urandom_range(1) ? KIND_HEAD : KIND_DATA;
      seq  = {$urandom, $urandom};
    end else if (pick < 95) begin
      seq = SEQ_MAX - 64'($urandom_range(3));
    end else begin
      kind = KIND_OTHER;
      seq  = {$urandom, $urandom};
    end
    send_item(kind, sid, seq);
  endtask

  task automatic test_random_traffic(logic [CFG_DATA_W-1:0] mode, int unsigned idle,
                                     bit pause_midway);
    int unsigned target;
    set_start_mode(mode);
    idle_pct = idle;
    target   = tracked_items + PHASE_ITEMS;
    while (tracked_items < target) begin
      send_random_item();
      // hold off once until the pipeline is empty
      if (pause_midway && tracked_items == target - PHASE_ITEMS / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    in_i            = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    latest_mode     = 1'b1;
    idle_pct        = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    tracked_items   = 0;
    ignored_items   = 0;
    deliveries_seen = 0;
    fetches_seen    = 0;
    foreach (seq_known[i]) begin
      seq_known[i] = 1'b0;
      seq_last[i]  = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_value();
    test_start_at_latest();
    test_start_at_earliest();
    test_random_traffic(32'd1, 0, 1'b0);
    test_random_traffic(32'd0, 68, 1'b1);
    test_random_traffic(32'd1, 25, 1'b1);
    test_random_traffic(32'd0, 0, 1'b0);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d tracked and %0d ignored beats in both start modes, idle 0/25/68%%.",
             tracked_items, ignored_items);
    $display("Saw %0d deliveries and %0d fetch requests.", deliveries_seen, fetches_seen);
    if (mismatch_count == 0 && expected_decisions.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
